/* sv/pwmtc_pkg.sv */
// ----------------------------------------------------------------------------
// PWM time-base calculator package
// Status codes, field widths and the record that travels through the duty
// scaling stage.
// ----------------------------------------------------------------------------
package pwmtc_pkg;

    localparam int FREQ_W   = 32;
    localparam int DUTY_W   = 10;
    localparam int PSC_W    = 16;
    localparam int REL_W    = 16;
    localparam int CMP_W    = 17;
    localparam int STAT_W   = 2;
    localparam int PROD_W   = CMP_W + DUTY_W;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FREQ = 2'd1;
    localparam logic [STAT_W-1:0] ST_DUTY = 2'd2;

    // Per-transaction record carried alongside the duty scaling math.
    typedef struct packed {
        logic [PSC_W-1:0]  psc;
        logic [REL_W-1:0]  rel;
        logic [CMP_W-1:0]  period;
        logic [STAT_W-1:0] status;
        logic              full;
    } t_scl;

endpackage

/* sv/pwm_timebase_and_compare_calc.sv */
// ----------------------------------------------------------------------------
// PWM time-base and compare calculator
// Pipeline: 32 + 32 divider stages, one product stage, one reciprocal
// multiply stage and one output register. Throughput: one transaction per
// cycle while the output is not stalled. Synchronous active-low
// reset clears all valid bits and loads the kernel clock register with 170000000.
// ----------------------------------------------------------------------------
module pwm_timebase_and_compare_calc #(
    parameter int DUTY_FULL_SCALE = 1000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_target_frequency_hz,
    input  logic [9:0]  i_duty_permille,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_prescaler_value,
    output logic [15:0] o_reload_value,
    output logic [16:0] o_compare_value,
    output logic [1:0]  o_status
);

    localparam int DW = pwmtc_pkg::DUTY_W;
    localparam logic [DW-1:0] FS = DW'(DUTY_FULL_SCALE);

    // The division by full scale is a multiplication by a rounded-up
    // reciprocal followed by a shift. With the shift set to the product width
    // plus the bits of full scale, the quotient is exact for every product
    // that fits in the product width.
    localparam int RL    = $clog2(DUTY_FULL_SCALE);
    localparam int RSH   = pwmtc_pkg::PROD_W + RL;
    localparam int RCP_W = pwmtc_pkg::PROD_W + 1;
    localparam int MUL_W = pwmtc_pkg::PROD_W + RCP_W;
    localparam logic [63:0] RECIP64 = ((64'd1 << RSH) + 64'(DUTY_FULL_SCALE) - 64'd1)
                                      / 64'(DUTY_FULL_SCALE);
    localparam logic [RCP_W-1:0] RECIP = RECIP64[RCP_W-1:0];

    // The whole pipeline moves when the output register is free or drained.
    logic en;
    assign en         = !o_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    logic [31:0] r_kclk;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kclk <= 32'd170000000;
        end else if (i_cfg_wr_en) begin
            r_kclk <= i_cfg_wr_data;
        end
    end

    // First division: total ticks = kernel clock / frequency. A zero frequency
    // is flagged in the sideband; the quotient is then meaningless.
    logic            d1_vld;
    logic [31:0]     d1_q;
    logic [DW:0]     d1_sb;

    pwmtc_div #(.N(32), .D(32), .SBW(DW + 1)) u_div_total (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_in_valid),
        .i_dividend (r_kclk),
        .i_divisor  (i_target_frequency_hz),
        .i_sb       ({i_target_frequency_hz == 32'd0, i_duty_permille}),
        .o_valid    (d1_vld),
        .o_quot     (d1_q),
        .o_sb       (d1_sb)
    );

    // Smallest prescaler that fits the reload value in 16 bits.
    logic        err1;
    logic [31:0] tm1;
    logic [15:0] psc;
    assign err1 = d1_sb[DW] || (d1_q < 32'd2);
    assign tm1  = d1_q - 32'd1;
    assign psc  = tm1[31:16];

    // Second division: period ticks = total / (prescaler + 1).
    logic               d2_vld;
    logic [31:0]        d2_q;
    logic [DW+16:0]     d2_sb;

    pwmtc_div #(.N(32), .D(17), .SBW(DW + 17)) u_div_period (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (d1_vld),
        .i_dividend (d1_q),
        .i_divisor  ({1'b0, psc} + 17'd1),
        .i_sb       ({err1, psc, d1_sb[DW-1:0]}),
        .o_valid    (d2_vld),
        .o_quot     (d2_q),
        .o_sb       (d2_sb)
    );

    // Reload check and status. A frequency error outranks a duty error.
    logic            err2;
    logic [DW-1:0]   duty2;
    pwmtc_pkg::t_scl rec2;
    assign duty2 = d2_sb[DW-1:0];
    assign err2  = d2_sb[DW+16] || (d2_q == 32'd1) || (d2_q > 32'd65536);

    always_comb begin
        logic [31:0] rel;
        rel         = d2_q - 32'd1;
        rec2.psc    = d2_sb[DW+15:DW];
        rec2.rel    = rel[15:0];
        rec2.period = d2_q[16:0];
        rec2.full   = duty2 >= FS;
        priority if (err2)       rec2.status = pwmtc_pkg::ST_FREQ;
        else if (duty2 > FS)     rec2.status = pwmtc_pkg::ST_DUTY;
        else                     rec2.status = pwmtc_pkg::ST_OK;
    end

    logic                         s_vld;
    logic [pwmtc_pkg::PROD_W-1:0] s_prod;
    pwmtc_pkg::t_scl              s_rec;

    pwmtc_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d2_vld),
        .i_duty  (duty2),
        .i_rec   (rec2),
        .o_valid (s_vld),
        .o_prod  (s_prod),
        .o_rec   (s_rec)
    );

    // Reciprocal stage: compare = (period * duty * reciprocal) >> shift.
    logic             r_mvld;
    logic [MUL_W-1:0] r_mul;
    pwmtc_pkg::t_scl  r_mrec;
    logic [16:0]      cmp_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvld <= 1'b0;
        end else if (en) begin
            r_mvld <= s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mul  <= MUL_W'(s_prod) * MUL_W'(RECIP);
            r_mrec <= s_rec;
        end
    end

    // Below full duty the quotient is under the period, so 17 bits hold it.
    assign cmp_q = 17'(r_mul >> RSH);

    // Output register; every value field is zeroed on an error status.
    logic [15:0] r_psc;
    logic [15:0] r_rel;
    logic [16:0] r_cmp;
    logic [1:0]  r_stat;
    logic        r_ovld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= r_mvld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_stat <= r_mrec.status;
            if (r_mrec.status == pwmtc_pkg::ST_OK) begin
                r_psc <= r_mrec.psc;
                r_rel <= r_mrec.rel;
                r_cmp <= r_mrec.full ? r_mrec.period : cmp_q;
            end else begin
                r_psc <= '0;
                r_rel <= '0;
                r_cmp <= '0;
            end
        end
    end

    assign o_out_valid       = r_ovld;
    assign o_prescaler_value = r_psc;
    assign o_reload_value    = r_rel;
    assign o_compare_value   = r_cmp;
    assign o_status          = r_stat;

endmodule

/* sv/pwmtc_div.sv */
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// One restoring quotient bit per stage, with a sideband word and a valid bit
// riding along each stage. All stages advance together on i_en.
// ----------------------------------------------------------------------------
module pwmtc_div #(
    parameter int N   = 32,
    parameter int D   = 32,
    parameter int SBW = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [N-1:0]   i_dividend,
    input  logic [D-1:0]   i_divisor,
    input  logic [SBW-1:0] i_sb,
    output logic           o_valid,
    output logic [N-1:0]   o_quot,
    output logic [SBW-1:0] o_sb
);

    logic           r_vld [N];
    logic [D-1:0]   r_rem [N];
    logic [N-1:0]   r_w   [N];
    logic [D-1:0]   r_dv  [N];
    logic [SBW-1:0] r_sb  [N];

    logic [D-1:0]   n_rem [N];
    logic [N-1:0]   n_w   [N];

    always_comb begin
        logic [D:0]   t;
        logic [D-1:0] prem;
        logic [N-1:0] pw;
        logic [D-1:0] pdv;
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                prem = '0;
                pw   = i_dividend;
                pdv  = i_divisor;
            end else begin
                prem = r_rem[k-1];
                pw   = r_w[k-1];
                pdv  = r_dv[k-1];
            end
            t = {prem, pw[N-1]};
            if (t >= {1'b0, pdv}) begin
                n_rem[k] = D'(t - {1'b0, pdv});
                n_w[k]   = {pw[N-2:0], 1'b1};
            end else begin
                n_rem[k] = t[D-1:0];
                n_w[k]   = {pw[N-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < N; k++) begin
                if (k == 0) begin
                    r_vld[k] <= i_valid;
                end else begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_rem[k] <= n_rem[k];
                r_w[k]   <= n_w[k];
                if (k == 0) begin
                    r_dv[k] <= i_divisor;
                    r_sb[k] <= i_sb;
                end else begin
                    r_dv[k] <= r_dv[k-1];
                    r_sb[k] <= r_sb[k-1];
                end
            end
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_quot  = r_w[N-1];
    assign o_sb    = r_sb[N-1];

endmodule

/* sv/pwmtc_scale.sv */
// ----------------------------------------------------------------------------
// Duty product stage
// Registers period times duty ahead of the division by full scale.
// ----------------------------------------------------------------------------
module pwmtc_scale (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [pwmtc_pkg::DUTY_W-1:0]     i_duty,
    input  pwmtc_pkg::t_scl                  i_rec,
    output logic                             o_valid,
    output logic [pwmtc_pkg::PROD_W-1:0]     o_prod,
    output pwmtc_pkg::t_scl                  o_rec
);

    logic                         r_vld;
    logic [pwmtc_pkg::PROD_W-1:0] r_prod;
    pwmtc_pkg::t_scl              r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= pwmtc_pkg::PROD_W'(i_rec.period) * pwmtc_pkg::PROD_W'(i_duty);
            r_rec  <= i_rec;
        end
    end

    assign o_valid = r_vld;
    assign o_prod  = r_prod;
    assign o_rec   = r_rec;

endmodule
